/* design/htfd_pkg.sv */
// Shared types, constants and helper functions for the sensor frame decoder.
`timescale 1ns / 1ps

package htfd_pkg;

  // Frame kinds as carried on the input selector and the result
  localparam logic KIND_MEAS = 1'b0;
  localparam logic KIND_ID   = 1'b1;

  // Byte positions of the two CRC bytes and of the second word's first byte
  localparam logic [2:0] POS_CRC1 = 3'd2;
  localparam logic [2:0] POS_CRC2 = 3'd5;
  localparam logic [2:0] POS_WORD2 = 3'd3;

  // CRC-8, poly 0x31, init 0xFF, MSB first
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Conversion: value = round(gain * raw / 65535) - offset
  localparam int PROD_W = 31;
  localparam logic [PROD_W-1:0] GAIN_T_CENTI = 31'd17500;
  localparam logic [PROD_W-1:0] GAIN_H_CENTI = 31'd10000;
  localparam logic [PROD_W-1:0] GAIN_T_WHOLE = 31'd175;
  localparam logic [PROD_W-1:0] GAIN_H_WHOLE = 31'd100;
  localparam logic [PROD_W-1:0] ROUND_BIAS   = 31'd32767;
  localparam logic [14:0] OFS_T_CENTI = 15'd4500;
  localparam logic [8:0]  OFS_T_WHOLE = 9'd45;

  // Completed frame handed from the byte tracker to the converter
  typedef struct packed {
    logic        kind;
    logic        ok;
    logic [15:0] t_raw;
    logic [15:0] h_raw;
    logic [15:0] id;
  } frame_evt_t;

  // One result word
  typedef struct packed {
    logic        frame_kind;
    logic        crc_ok;
    logic [14:0] temp_centi;
    logic [13:0] humi_centi;
    logic [8:0]  temp_whole;
    logic [6:0]  humi_whole;
    logic [15:0] device_id;
  } result_t;

  // One byte through the CRC register
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // floor(x / 65535) for quotients below 65536: 65536 == 1 mod 65535
  function automatic logic [15:0] div_65535(input logic [PROD_W-1:0] x);
    logic [31:0] s;
    s = {1'b0, x} + {17'd0, x[PROD_W-1:16]} + 32'd1;
    return s[31:16];
  endfunction

endpackage

/* design/htfd_frame.sv */
// Byte tracker: frame position, running CRC, word capture and stored ID.
`timescale 1ns / 1ps

module htfd_frame (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic                 in_first,
  input  logic [7:0]           in_byte,
  output logic                 evt_valid,
  input  logic                 evt_ready,
  output htfd_pkg::frame_evt_t evt
);

  logic [2:0]  byte_position, byte_position_next;
  logic        latched_kind, latched_kind_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [15:0] first_word, first_word_next;
  logic [15:0] second_word, second_word_next;
  logic        first_crc_good, first_crc_good_next;
  logic [15:0] stored_id, stored_id_next;
  logic        evt_valid_next;
  htfd_pkg::frame_evt_t evt_next;

  logic       accept;
  logic [2:0] pos_eff;
  logic [7:0] crc_eff;
  logic       kind_eff;
  logic       match;
  logic       fire;

  assign in_ready = !evt_valid || evt_ready;
  assign accept   = in_valid && in_ready;

  // Per-byte state update
  always_comb begin
    byte_position_next  = byte_position;
    latched_kind_next   = latched_kind;
    running_crc_next    = running_crc;
    first_word_next     = first_word;
    second_word_next    = second_word;
    first_crc_good_next = first_crc_good;
    stored_id_next      = stored_id;
    fire                = 1'b0;

    pos_eff  = in_first ? 3'd0 : byte_position;
    crc_eff  = in_first ? htfd_pkg::CRC_INIT : running_crc;
    kind_eff = in_first ? in_kind : latched_kind;
    match    = (in_byte == crc_eff);

    evt_next.kind  = kind_eff;
    evt_next.ok    = (kind_eff == htfd_pkg::KIND_ID) ? match : (first_crc_good && match);
    evt_next.t_raw = first_word;
    evt_next.h_raw = second_word;
    evt_next.id    = (kind_eff == htfd_pkg::KIND_ID && match) ? first_word : stored_id;

    if (accept) begin
      latched_kind_next = kind_eff;
      if (pos_eff != htfd_pkg::POS_CRC1 && pos_eff != htfd_pkg::POS_CRC2) begin
        // data byte
        running_crc_next = htfd_pkg::crc8_byte(crc_eff, in_byte);
        if (pos_eff < htfd_pkg::POS_CRC1) begin
          first_word_next = {first_word[7:0], in_byte};
        end else begin
          second_word_next = {second_word[7:0], in_byte};
        end
        byte_position_next = pos_eff + 3'd1;
      end else begin
        // CRC byte
        running_crc_next = htfd_pkg::CRC_INIT;
        if (pos_eff == htfd_pkg::POS_CRC1 && kind_eff == htfd_pkg::KIND_MEAS) begin
          first_crc_good_next = match;
          byte_position_next  = htfd_pkg::POS_WORD2;
        end else begin
          byte_position_next = 3'd0;
          fire               = 1'b1;
          if (kind_eff == htfd_pkg::KIND_ID && match) begin
            stored_id_next = first_word;
          end
        end
      end
    end

    evt_valid_next = in_ready ? fire : evt_valid;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= 3'd0;
      latched_kind   <= htfd_pkg::KIND_MEAS;
      running_crc    <= htfd_pkg::CRC_INIT;
      first_word     <= 16'd0;
      second_word    <= 16'd0;
      first_crc_good <= 1'b0;
      stored_id      <= 16'd0;
      evt_valid      <= 1'b0;
    end else begin
      byte_position  <= byte_position_next;
      latched_kind   <= latched_kind_next;
      running_crc    <= running_crc_next;
      first_word     <= first_word_next;
      second_word    <= second_word_next;
      first_crc_good <= first_crc_good_next;
      stored_id      <= stored_id_next;
      evt_valid      <= evt_valid_next;
    end
  end

  // Frame result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      evt <= evt_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A CRC byte closing a frame always puts the tracker back to the start
  a_end_resets_pos: assert property (@(posedge clk) disable iff (rst)
    fire |=> (byte_position == 3'd0 && running_crc == htfd_pkg::CRC_INIT))
    else $error("frame end did not restart position/CRC");
  // Position never runs past the last CRC byte
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= htfd_pkg::POS_CRC2)
    else $error("byte position out of range");
  // A waiting frame result is never overwritten
  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_ready |=> evt_valid && $stable(evt))
    else $error("frame result lost while stalled");
`endif

endmodule

/* design/htfd_conv.sv */
// Two-stage conversion of raw words to scaled, rounded temperature and humidity.
`timescale 1ns / 1ps

module htfd_conv (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 evt_valid,
  output logic                 evt_ready,
  input  htfd_pkg::frame_evt_t evt,
  output logic                 res_valid,
  input  logic                 res_ready,
  output htfd_pkg::result_t    res
);

  typedef struct packed {
    logic                        kind;
    logic                        ok;
    logic [15:0]                 id;
    logic [htfd_pkg::PROD_W-1:0] xtc;
    logic [htfd_pkg::PROD_W-1:0] xhc;
    logic [htfd_pkg::PROD_W-1:0] xtw;
    logic [htfd_pkg::PROD_W-1:0] xhw;
  } conv_stage_t;

  logic        a_valid;
  conv_stage_t a_q, a_d;
  logic        out_ready;
  htfd_pkg::result_t res_d;
  logic [15:0] q_tc, q_hc, q_tw, q_hw;
  logic        conv_en;

  assign out_ready = !res_valid || res_ready;
  assign evt_ready = !a_valid || out_ready;

  // Stage A: constant gains plus rounding bias
  always_comb begin
    a_d.kind = evt.kind;
    a_d.ok   = evt.ok;
    a_d.id   = evt.id;
    a_d.xtc  = {15'd0, evt.t_raw} * htfd_pkg::GAIN_T_CENTI + htfd_pkg::ROUND_BIAS;
    a_d.xhc  = {15'd0, evt.h_raw} * htfd_pkg::GAIN_H_CENTI + htfd_pkg::ROUND_BIAS;
    a_d.xtw  = {15'd0, evt.t_raw} * htfd_pkg::GAIN_T_WHOLE + htfd_pkg::ROUND_BIAS;
    a_d.xhw  = {15'd0, evt.h_raw} * htfd_pkg::GAIN_H_WHOLE + htfd_pkg::ROUND_BIAS;
  end

  // Stage B: divide by full scale, remove offset, zero unless a good measurement
  always_comb begin
    q_tc    = htfd_pkg::div_65535(a_q.xtc);
    q_hc    = htfd_pkg::div_65535(a_q.xhc);
    q_tw    = htfd_pkg::div_65535(a_q.xtw);
    q_hw    = htfd_pkg::div_65535(a_q.xhw);
    conv_en = a_q.ok && (a_q.kind == htfd_pkg::KIND_MEAS);

    res_d.frame_kind = a_q.kind;
    res_d.crc_ok     = a_q.ok;
    res_d.device_id  = a_q.id;
    res_d.temp_centi = conv_en ? (q_tc[14:0] - htfd_pkg::OFS_T_CENTI) : 15'd0;
    res_d.humi_centi = conv_en ? q_hc[13:0] : 14'd0;
    res_d.temp_whole = conv_en ? (q_tw[8:0] - htfd_pkg::OFS_T_WHOLE) : 9'd0;
    res_d.humi_whole = conv_en ? q_hw[6:0] : 7'd0;
  end

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (evt_ready) begin
        a_valid <= evt_valid;
      end
      if (out_ready) begin
        res_valid <= a_valid;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (evt_valid && evt_ready) begin
      a_q <= a_d;
    end
    if (a_valid && out_ready) begin
      res <= res_d;
    end
  end

`ifndef NO_ASSERTIONS
  // Values are zero for identity frames and failed checks
  a_zero_fill: assert property (@(posedge clk) disable iff (rst)
    res_valid && (!res.crc_ok || res.frame_kind == htfd_pkg::KIND_ID) |->
      (res.temp_centi == 15'd0 && res.humi_centi == 14'd0 &&
       res.temp_whole == 9'd0 && res.humi_whole == 7'd0))
    else $error("nonzero values on a frame without measurement");
  // Converted values stay within the sensor's scale
  a_scale: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ($signed(res.temp_centi) >= -15'sd4500 &&
                   $signed(res.temp_centi) <= 15'sd13000 &&
                   res.humi_centi <= 14'd10000 && res.humi_whole <= 7'd100 &&
                   $signed(res.temp_whole) >= -9'sd45 &&
                   $signed(res.temp_whole) <= 9'sd130))
    else $error("converted value out of range");
  // Stage A keeps its word while the result register is blocked
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && res_valid && !res_ready |=> a_valid && $stable(a_q))
    else $error("conversion stage dropped a word");
  // Reset empties stage A and the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && !a_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

/* design/humidity_temp_frame_decoder.sv */
// Top level of the temperature/humidity sensor frame decoder.
`timescale 1ns / 1ps

// Takes received sensor bytes one byte per cycle, checks each 16-bit sensor
// word against its CRC-8 (poly 0x31, init 0xFF) and emits one result word per
// completed frame: six bytes for a measurement frame, three for an identity
// frame. A byte is accepted every cycle while the output is not blocked; the
// result of a frame passes the frame-result register, which loads on the edge
// that accepts its last byte, then the gain stage, then the divide-and-offset
// stage into the output register. The per-byte CRC update is the single
// byte-wide step on the input side; the conversion divides by full scale
// 65535 with an add-and-shift.
module humidity_temp_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [0] operation, [1] first_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [14:0] temp_centi, [28:15] humi_centi,
                                 // [37:29] temp_whole, [44:38] humi_whole,
                                 // [60:45] device_id, [63:61] zero
  output logic [1:0]  m_tuser    // [0] frame_kind, [1] crc_ok
);

  logic                 evt_valid;
  logic                 evt_ready;
  htfd_pkg::frame_evt_t evt;
  htfd_pkg::result_t    res;

  // Byte tracking and CRC checks
  htfd_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser[0]),
    .in_first  (s_tuser[1]),
    .in_byte   (s_tdata),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt)
  );

  // Scaling and rounding
  htfd_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  // Output word packing
  assign m_tdata = {3'b000, res.device_id, res.humi_whole, res.temp_whole,
                    res.humi_centi, res.temp_centi};
  assign m_tuser = {res.crc_ok, res.frame_kind};

endmodule

/* tb/sv/tb_humidity_temp_frame_decoder.sv */
// Self-checking testbench for the sensor frame decoder: CRC, conversion and ID tracking.
`timescale 1ns / 1ps

module tb_humidity_temp_frame_decoder;

  localparam int  CYCLE_LIMIT   = 1_000_000;
  localparam int  RANDOM_WORDS  = 1450;
  localparam int  LONG_HOLD     = 300;
  localparam int  DRAIN_CYCLES  = 20;
  localparam longint FULL_SCALE = 65535;

  // Tracks the decoder state byte by byte and holds the readings still owed
  class sensor_reading_tracker;
    bit [2:0]  byte_idx;
    bit        cur_kind;
    bit [7:0]  crc_acc;
    bit [15:0] word_a;
    bit [15:0] word_b;
    bit        word_a_good;
    bit [15:0] dev_id;
    htfd_pkg::result_t pending[$];
    int        errors;

    function new();
      byte_idx    = 3'd0;
      cur_kind    = htfd_pkg::KIND_MEAS;
      crc_acc     = 8'hFF;
      word_a      = 16'd0;
      word_b      = 16'd0;
      word_a_good = 1'b0;
      dev_id      = 16'd0;
      errors      = 0;
    endfunction

    // CRC-8, poly 0x31, MSB first, one byte
    function bit [7:0] crc_step(bit [7:0] c, bit [7:0] d);
      bit [7:0] r;
      r = c ^ d;
      for (int k = 0; k < 8; k++) begin
        r = r[7] ? ((r << 1) ^ 8'h31) : (r << 1);
      end
      return r;
    endfunction

    function bit [7:0] word_crc(bit [15:0] w);
      return crc_step(crc_step(8'hFF, w[15:8]), w[7:0]);
    endfunction

    // num / den rounded to nearest, halves away from zero
    function longint div_nearest(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      return (num < 0) ? -q : q;
    endfunction

    // Accepted input byte: advance the frame and queue a reading at frame end
    function void note_byte(bit op, bit first, bit [7:0] d);
      bit [2:0] p;
      bit       match;
      bit       ok;
      longint   rt, rh, tc, hc, tw, hw;
      htfd_pkg::result_t r;
      if (first) begin
        byte_idx = 3'd0;
        cur_kind = op;
        crc_acc  = 8'hFF;
      end
      p = byte_idx;
      if (p != 3'd2 && p != 3'd5) begin
        crc_acc = crc_step(crc_acc, d);
        if (p < 3'd2) word_a = {word_a[7:0], d};
        else word_b = {word_b[7:0], d};
        byte_idx = p + 3'd1;
        return;
      end
      match   = (d == crc_acc);
      crc_acc = 8'hFF;
      if (p == 3'd2 && cur_kind == htfd_pkg::KIND_MEAS) begin
        word_a_good = match;
        byte_idx = 3'd3;
        return;
      end
      byte_idx = 3'd0;
      r = '0;
      if (cur_kind == htfd_pkg::KIND_ID) begin
        if (match) dev_id = word_a;
        r.frame_kind = htfd_pkg::KIND_ID;
        r.crc_ok = match;
      end else begin
        ok = word_a_good && match;
        r.frame_kind = htfd_pkg::KIND_MEAS;
        r.crc_ok = ok;
        if (ok) begin
          rt = longint'(word_a);
          rh = longint'(word_b);
          tc = div_nearest(17500 * rt - 4500 * FULL_SCALE, FULL_SCALE);
          hc = div_nearest(10000 * rh, FULL_SCALE);
          tw = div_nearest(175 * rt - 45 * FULL_SCALE, FULL_SCALE);
          hw = div_nearest(100 * rh, FULL_SCALE);
          r.temp_centi = tc[14:0];
          r.humi_centi = hc[13:0];
          r.temp_whole = tw[8:0];
          r.humi_whole = hw[6:0];
        end
      end
      r.device_id = dev_id;
      pending.push_back(r);
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, what);
    endfunction

    function void cmp(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v)
        flag($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v));
    endfunction

    // Accepted result word against the oldest pending reading
    function void check_reading(logic [63:0] d, logic [1:0] u);
      htfd_pkg::result_t e;
      if (pending.size() == 0) begin
        flag("result word with no frame pending");
        return;
      end
      e = pending.pop_front();
      cmp("frame_kind", 16'(e.frame_kind), 16'(u[0]));
      cmp("crc_ok",     16'(e.crc_ok),     16'(u[1]));
      cmp("temp_centi", 16'(e.temp_centi), 16'(d[14:0]));
      cmp("humi_centi", 16'(e.humi_centi), 16'(d[28:15]));
      cmp("temp_whole", 16'(e.temp_whole), 16'(d[37:29]));
      cmp("humi_whole", 16'(e.humi_whole), 16'(d[44:38]));
      cmp("device_id",  e.device_id,       d[60:45]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] data_byte
  logic [1:0]  s_tuser = 2'd0;   // [0] operation, [1] first_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;          // temp_centi, humi_centi, temp_whole, humi_whole, device_id
  logic [1:0]  m_tuser;          // [0] frame_kind, [1] crc_ok

  sensor_reading_tracker readings = new();
  int  words_sent = 0;
  int  cycles = 0;
  bit  send_calm = 1'b0;
  bit  hold_req = 1'b0;

  humidity_temp_frame_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(($urandom_range(0, 1) == 0) ? 16'h7FFF : 16'h8000);
      3: return 16'($urandom_range(0, 40));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offer one byte and wait for its handshake
  task automatic send_byte(bit op, bit first, bit [7:0] d);
    int gap;
    gap = send_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= {first, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    readings.note_byte(op, first, d);
    words_sent++;
  endtask

  // Whole frame; CRC bytes optionally corrupted; first byte marked or not
  task automatic send_frame(bit kind, bit [15:0] w1, bit [15:0] w2,
                            bit bad1, bit bad2, bit marked);
    bit [7:0] c1, c2;
    c1 = readings.word_crc(w1) ^ (bad1 ? 8'($urandom_range(1, 255)) : 8'd0);
    c2 = readings.word_crc(w2) ^ (bad2 ? 8'($urandom_range(1, 255)) : 8'd0);
    send_byte(marked ? kind : 1'($urandom_range(0, 1)), marked, w1[15:8]);
    send_byte(1'($urandom_range(0, 1)), 1'b0, w1[7:0]);
    send_byte(1'($urandom_range(0, 1)), 1'b0, c1);
    if (kind == htfd_pkg::KIND_MEAS) begin
      send_byte(1'($urandom_range(0, 1)), 1'b0, w2[15:8]);
      send_byte(1'($urandom_range(0, 1)), 1'b0, w2[7:0]);
      send_byte(1'($urandom_range(0, 1)), 1'b0, c2);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (readings.pending.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, calm stretches, one long hold-off on request
  initial begin : result_sink
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit calm = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) readings.check_reading(m_tdata, m_tuser);
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_left = calm ? 0 : pick_gap();
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int  sel, n;
    bit  kind, marked, bad1, bad2;
    bit  paused = 1'b0;
    bit  held = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: scale extremes, unmarked follow-on frame, ID good and bad,
    // aborted partial frame, bad first CRC
    send_frame(htfd_pkg::KIND_MEAS, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
    send_frame(htfd_pkg::KIND_MEAS, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
    send_frame(htfd_pkg::KIND_ID,   16'hA5C3, 16'h0000, 1'b0, 1'b0, 1'b1);
    send_frame(htfd_pkg::KIND_ID,   16'h1234, 16'h0000, 1'b1, 1'b0, 1'b1);
    send_byte(htfd_pkg::KIND_ID, 1'b1, 8'h5A);
    send_byte(htfd_pkg::KIND_MEAS, 1'b0, 8'h00);
    send_frame(htfd_pkg::KIND_MEAS, 16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1);

    // Random: mostly well-formed frames, some broken, some noise
    while (words_sent < RANDOM_WORDS) begin
      sel = $urandom_range(0, 99);
      send_calm = ($urandom_range(0, 4) == 0);
      if (!paused && words_sent > 500) begin
        paused = 1'b1;
        wait_drained();
      end
      if (!held && words_sent > 900) begin
        // Long result hold-off while words keep coming back to back
        held = 1'b1;
        hold_req = 1'b1;
        send_calm = 1'b1;
        repeat (30) send_frame(htfd_pkg::KIND_MEAS, pick_word(), pick_word(),
                               1'b0, 1'b0, 1'b1);
        send_calm = 1'b0;
      end
      if (sel < 86) begin
        kind = ($urandom_range(0, 2) == 0) ? htfd_pkg::KIND_ID : htfd_pkg::KIND_MEAS;
        marked = !(readings.byte_idx == 3'd0 && $urandom_range(0, 3) == 0);
        if (!marked) kind = readings.cur_kind;
        bad1 = 1'b0;
        bad2 = 1'b0;
        if (sel >= 72) begin
          n = $urandom_range(1, 3);
          bad1 = n[0] || (kind == htfd_pkg::KIND_ID);
          bad2 = n[1];
        end
        send_frame(kind, pick_word(), pick_word(), bad1, bad2, marked);
      end else if (sel < 94) begin
        // Partial frame, dropped by the next first mark
        n = $urandom_range(1, 5);
        send_byte(1'($urandom_range(0, 1)), 1'b1, 8'($urandom_range(0, 255)));
        repeat (n - 1) send_byte(1'($urandom_range(0, 1)), 1'b0, 8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (readings.errors == 0 && readings.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
